[hw/rtl/stq_pkg.sv]
// Shared constants, types and helpers of the sorted timer queue.
`default_nettype none
package stq_pkg;

   localparam int NUM_TIMERS = 64;
   localparam int TIME_BITS  = 32;
   localparam int ID_BITS    = 6;
   localparam int ID_SPACE   = 2 ** ID_BITS;
   localparam int PTR_BITS   = $clog2(NUM_TIMERS);
   localparam int CNT_BITS   = $clog2(NUM_TIMERS + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_ADJUST = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_DUPLICATE  = 2'd1;
   localparam logic [1:0] ST_NOT_ACTIVE = 2'd2;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] expiry;
   } entry_type;

   typedef struct packed {
      logic                wr_en;
      logic [PTR_BITS-1:0] wr_addr;
      entry_type           wr_data;
      logic                rd_en;
      logic [PTR_BITS-1:0] rd_addr;
   } mem_req_type;

   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] base,
                                                   input logic [CNT_BITS-1:0] off);
      logic [CNT_BITS:0] sum;
      sum = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(off);
      if (sum >= (CNT_BITS+1)'(NUM_TIMERS)) begin
         sum = sum - (CNT_BITS+1)'(NUM_TIMERS);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/sorted_timer_queue_core.sv]
// Top level of the sorted timer queue: request sequencer around the entry memory.
//
// Requests enter on the req_ stream (opcode in req_tuser) and results leave on
// the rsp_ stream. Add, adjust and delete give one result each; a tick gives one
// result per expired timer, in expiry order, with rsp_tlast on the final one, or
// a single empty result when nothing expired.
// Timers sit in a circular memory in expiry order, at most one entry read per cycle.
// An add walks back from the tail, shifting each timer that expires later than
// the new time up one place, then writes the new entry. A delete searches from
// the head; a timer at the head is dropped by moving the head on, any other by
// shifting the entries behind it down over the gap. An adjust deletes and then
// adds. A tick retires head entries while they have expired. All of these walks
// share the single memory read port. A full result register holds while
// rsp_tready is low, and the sequencer waits for it.
// One request is worked on at a time; req_tready is high only between requests.
// Reset empties the queue at once (no clearing pass); memory contents are not
// cleared since no entry is read before it is written.
`default_nettype none
module sorted_timer_queue_core
   import stq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [71:0] req_tdata,  // timer_id, expire_time, current_time, zero pad
   input  wire logic [1:0]  req_tuser,  // opcode
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,  // expired_id, active_count, zero pad
   output      logic [2:0]  rsp_tuser,  // status, expired_valid
   output      logic        rsp_tlast   // last
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_INS_START = 4'd2;
   localparam logic [3:0] S_INS       = 4'd3;
   localparam logic [3:0] S_INS_LAST  = 4'd4;
   localparam logic [3:0] S_FIND      = 4'd5;
   localparam logic [3:0] S_SHIFT     = 4'd6;
   localparam logic [3:0] S_EMIT      = 4'd7;
   localparam logic [3:0] S_TICK_RD   = 4'd8;
   localparam logic [3:0] S_TICK_CHK  = 4'd9;
   localparam logic [3:0] S_TICK_END  = 4'd10;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          op_ff, op_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [TIME_BITS-1:0] exp_ff, exp_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [ID_SPACE-1:0] active_ff, active_in;
   logic [CNT_BITS-1:0] off_ff, off_in;
   logic [1:0]          status_ff, status_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]  pend_id_ff, pend_id_in;
   logic [CNT_BITS-1:0] pend_count_ff, pend_count_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic                rsp_exp_valid_ff, rsp_exp_valid_in;
   logic [ID_BITS-1:0]  rsp_exp_id_ff, rsp_exp_id_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [CNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   mem_req_type         mem_req;
   entry_type           rd_data;
   entry_type           new_entry;
   logic                out_free;
   logic                rsp_load;
   logic                id_in_range;
   logic [CNT_BITS-1:0] off_next;
   logic [CNT_BITS-1:0] off_prev;
   logic                req_accept;

   stq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign id_in_range = (int'(id_ff) < NUM_TIMERS);
   assign off_next    = off_ff + 1'b1;
   assign off_prev    = off_ff - 1'b1;
   assign new_entry   = '{id: id_ff, expiry: exp_ff};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      exp_in        = exp_ff;
      now_in        = now_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      active_in     = active_ff;
      off_in        = off_ff;
      status_in     = status_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_count_in = pend_count_ff;
      mem_req       = '0;
      rsp_load         = 1'b0;
      rsp_status_in    = rsp_status_ff;
      rsp_exp_valid_in = rsp_exp_valid_ff;
      rsp_exp_id_in    = rsp_exp_id_ff;
      rsp_last_in      = rsp_last_ff;
      rsp_count_in     = rsp_count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = req_tuser;
               id_in    = req_tdata[5:0];
               exp_in   = TIME_BITS'(req_tdata[37:6]);
               now_in   = TIME_BITS'(req_tdata[69:38]);
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = ST_OK;
            if (op_ff == OP_TICK) begin
               state_in = S_TICK_RD;
            end else if (op_ff == OP_ADD) begin
               if (!id_in_range) begin
                  status_in = ST_NOT_ACTIVE;
                  state_in  = S_EMIT;
               end else if (active_ff[id_ff]) begin
                  status_in = ST_DUPLICATE;
                  state_in  = S_EMIT;
               end else begin
                  active_in[id_ff] = 1'b1;
                  state_in         = S_INS_START;
               end
            end else begin
               if (!id_in_range || !active_ff[id_ff]) begin
                  status_in = ST_NOT_ACTIVE;
                  state_in  = S_EMIT;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = head_ff;
                  off_in          = '0;
                  state_in        = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (rd_data.id == id_ff) begin
               if (off_ff == '0) begin
                  head_in  = ptr_add(head_ff, CNT_BITS'(1));
                  count_in = count_ff - 1'b1;
                  state_in = (op_ff == OP_DELETE) ? S_EMIT : S_INS_START;
                  if (op_ff == OP_DELETE) begin
                     active_in[id_ff] = 1'b0;
                  end
               end else if (off_next < count_ff) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ptr_add(head_ff, off_next);
                  off_in          = off_next;
                  state_in        = S_SHIFT;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = (op_ff == OP_DELETE) ? S_EMIT : S_INS_START;
                  if (op_ff == OP_DELETE) begin
                     active_in[id_ff] = 1'b0;
                  end
               end
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_add(head_ff, off_next);
               off_in          = off_next;
            end
         end
         S_SHIFT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_add(head_ff, off_prev);
            mem_req.wr_data = rd_data;
            if (off_next < count_ff) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_add(head_ff, off_next);
               off_in          = off_next;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = (op_ff == OP_DELETE) ? S_EMIT : S_INS_START;
               if (op_ff == OP_DELETE) begin
                  active_in[id_ff] = 1'b0;
               end
            end
         end
         S_INS_START: begin
            if (count_ff == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = head_ff;
               mem_req.wr_data = new_entry;
               count_in        = count_ff + 1'b1;
               state_in        = S_EMIT;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ptr_add(head_ff, count_ff - 1'b1);
               off_in          = count_ff - 1'b1;
               state_in        = S_INS;
            end
         end
         S_INS: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ptr_add(head_ff, off_next);
            if (rd_data.expiry > exp_ff) begin
               mem_req.wr_data = rd_data;
               if (off_ff == '0) begin
                  state_in = S_INS_LAST;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = ptr_add(head_ff, off_prev);
                  off_in          = off_prev;
               end
            end else begin
               mem_req.wr_data = new_entry;
               count_in        = count_ff + 1'b1;
               state_in        = S_EMIT;
            end
         end
         S_INS_LAST: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = head_ff;
            mem_req.wr_data = new_entry;
            count_in        = count_ff + 1'b1;
            state_in        = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_load         = 1'b1;
               rsp_status_in    = status_ff;
               rsp_exp_valid_in = 1'b0;
               rsp_exp_id_in    = '0;
               rsp_last_in      = 1'b1;
               rsp_count_in     = count_ff;
               state_in         = S_IDLE;
            end
         end
         S_TICK_RD: begin
            if (count_ff == '0) begin
               state_in = S_TICK_END;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = head_ff;
               state_in        = S_TICK_CHK;
            end
         end
         S_TICK_CHK: begin
            if (now_ff >= rd_data.expiry) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_load         = 1'b1;
                     rsp_status_in    = ST_OK;
                     rsp_exp_valid_in = 1'b1;
                     rsp_exp_id_in    = pend_id_ff;
                     rsp_last_in      = 1'b0;
                     rsp_count_in     = pend_count_ff;
                  end
                  head_in                 = ptr_add(head_ff, CNT_BITS'(1));
                  count_in                = count_ff - 1'b1;
                  active_in[rd_data.id]   = 1'b0;
                  pend_valid_in           = 1'b1;
                  pend_id_in              = rd_data.id;
                  pend_count_in           = count_ff - 1'b1;
                  state_in                = S_TICK_RD;
               end
            end else begin
               state_in = S_TICK_END;
            end
         end
         S_TICK_END: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
               if (pend_valid_ff) begin
                  rsp_exp_valid_in = 1'b1;
                  rsp_exp_id_in    = pend_id_ff;
                  rsp_count_in     = pend_count_ff;
               end else begin
                  rsp_exp_valid_in = 1'b0;
                  rsp_exp_id_in    = '0;
                  rsp_count_in     = count_ff;
               end
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      id_ff            <= id_in;
      exp_ff           <= exp_in;
      now_ff           <= now_in;
      off_ff           <= off_in;
      status_ff        <= status_in;
      pend_id_ff       <= pend_id_in;
      pend_count_ff    <= pend_count_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_exp_valid_ff <= rsp_exp_valid_in;
      rsp_exp_id_ff    <= rsp_exp_id_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, 7'(rsp_count_ff), rsp_exp_id_ff};
   assign rsp_tuser  = {rsp_exp_valid_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= NUM_TIMERS)
      else $error("timer count above capacity");

   a_active_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(active_ff) == int'(count_ff)))
      else $error("active map disagrees with timer count");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("sequencer took a request but stayed idle");

   a_expired_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_exp_valid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("expired result carries an error status");

endmodule
`default_nettype wire

[hw/rtl/stq_store.sv]
// Sorted entry memory: one write and one registered read port.
`default_nettype none
module stq_store
   import stq_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output      entry_type   rd_data
);

   entry_type ent_mem [NUM_TIMERS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         ent_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= ent_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[tb/sorted_timer_queue_core_checker.sv]
// Checker for the sorted timer queue: watches both streams, predicts and compares results.
`timescale 1ns / 1ps
module sorted_timer_queue_core_checker
   import stq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,  // timer_id, expire_time, current_time, zero pad
   input  wire logic [1:0]  req_tuser,  // opcode
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,  // expired_id, active_count, zero pad
   input  wire logic [2:0]  rsp_tuser,  // status, expired_valid
   input  wire logic        rsp_tlast,
   output int               error_count,
   output int               pending,
   output int               results_checked,
   output int               timers_expired
);

   typedef struct packed {
      logic [1:0]          status;
      logic                expired;
      logic [ID_BITS-1:0]  expired_id;
      logic                last;
      logic [CNT_BITS-1:0] count;
   } timer_result_type;

   timer_result_type     results_due[$];
   logic [ID_BITS-1:0]   ids_by_expiry[$];
   logic [TIME_BITS-1:0] expiry_of[ID_SPACE];
   bit                   armed[ID_SPACE];

   function automatic void expect_result(input logic [1:0] status, input logic expired,
                                         input logic [ID_BITS-1:0] id, input logic last);
      timer_result_type r;
      r.status     = status;
      r.expired    = expired;
      r.expired_id = id;
      r.last       = last;
      r.count      = CNT_BITS'(ids_by_expiry.size());
      results_due.push_back(r);
   endfunction

   // place after every held timer expiring at or before this one
   function automatic void insert_by_expiry(input logic [ID_BITS-1:0] id);
      int pos;
      pos = 0;
      while (pos < ids_by_expiry.size() && expiry_of[ids_by_expiry[pos]] <= expiry_of[id]) begin
         pos++;
      end
      ids_by_expiry.insert(pos, id);
   endfunction

   function automatic void predict_request(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                                           input logic [TIME_BITS-1:0] expire,
                                           input logic [TIME_BITS-1:0] now);
      logic [ID_BITS-1:0] head;
      logic               more;
      int                 fired;
      int                 k;
      fired = 0;
      if (op == OP_TICK) begin
         while (ids_by_expiry.size() > 0 && expiry_of[ids_by_expiry[0]] <= now) begin
            head = ids_by_expiry.pop_front();
            armed[head] = 1'b0;
            more = ids_by_expiry.size() > 0 && expiry_of[ids_by_expiry[0]] <= now;
            expect_result(ST_OK, 1'b1, head, !more);
            fired++;
         end
         if (fired == 0) begin
            expect_result(ST_OK, 1'b0, '0, 1'b1);
         end
      end else if (op == OP_ADD && armed[id]) begin
         expect_result(ST_DUPLICATE, 1'b0, '0, 1'b1);
      end else if (op != OP_ADD && !armed[id]) begin
         expect_result(ST_NOT_ACTIVE, 1'b0, '0, 1'b1);
      end else begin
         if (op != OP_ADD) begin
            for (k = ids_by_expiry.size() - 1; k >= 0; k--) begin
               if (ids_by_expiry[k] == id) begin
                  ids_by_expiry.delete(k);
               end
            end
         end
         if (op == OP_DELETE) begin
            armed[id] = 1'b0;
         end else begin
            expiry_of[id] = expire;
            armed[id]     = 1'b1;
            insert_by_expiry(id);
         end
         expect_result(ST_OK, 1'b0, '0, 1'b1);
      end
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : watch
      timer_result_type want;
      if (reset) begin
         results_due.delete();
         ids_by_expiry.delete();
         foreach (armed[i]) begin
            armed[i] = 1'b0;
         end
         error_count     = 0;
         results_checked = 0;
         timers_expired  = 0;
      end else begin
         // results belong to older requests, so compare before predicting
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               $error("unexpected result: status %0d, expired_id %0d",
                      rsp_tuser[1:0], rsp_tdata[5:0]);
               error_count++;
            end else begin
               want = results_due.pop_front();
               check_field("status", int'(want.status), int'(rsp_tuser[1:0]));
               check_field("expired_valid", int'(want.expired), int'(rsp_tuser[2]));
               check_field("expired_id", int'(want.expired_id), int'(rsp_tdata[5:0]));
               check_field("active_count", int'(want.count), int'(rsp_tdata[12:6]));
               check_field("last", int'(want.last), int'(rsp_tlast));
               results_checked++;
               if (want.expired) begin
                  timers_expired++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata[5:0], req_tdata[37:6], req_tdata[69:38]);
         end
      end
      pending = results_due.size();
   end

endmodule

[tb/sorted_timer_queue_core_tb.sv]
// Testbench top for the sorted timer queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module sorted_timer_queue_core_tb;
   import stq_pkg::*;

   localparam int DRAIN_CYCLES = 2 * NUM_TIMERS + 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;  // timer_id, expire_time, current_time, zero pad
   logic [1:0]  req_tuser  = '0;  // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // expired_id, active_count, zero pad
   logic [2:0]  rsp_tuser;        // status, expired_valid
   logic        rsp_tlast;

   int error_count;
   int pending;
   int results_checked;
   int timers_expired;

   int send_idle_pct = 7;
   int recv_idle_pct = 72;
   int sent_by_op[4];

   // stimulus-side view of which ids are held, to steer requests at live timers
   bit                   held[ID_SPACE];
   logic [TIME_BITS-1:0] held_expiry[ID_SPACE];
   logic [TIME_BITS-1:0] base_time;

   sorted_timer_queue_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sorted_timer_queue_core_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .error_count     (error_count),
      .pending         (pending),
      .results_checked (results_checked),
      .timers_expired  (timers_expired)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_request(input logic [1:0] op, input logic [ID_BITS-1:0] id,
                               input logic [TIME_BITS-1:0] expire,
                               input logic [TIME_BITS-1:0] now);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, now, expire, id};
      do begin
         @(posedge clock);
      end while (!req_tready);
      sent_by_op[op]++;
      case (op)
         OP_ADD: begin
            if (!held[id]) begin
               held[id]        = 1'b1;
               held_expiry[id] = expire;
            end
         end
         OP_ADJUST: begin
            if (held[id]) begin
               held_expiry[id] = expire;
            end
         end
         OP_DELETE: begin
            held[id] = 1'b0;
         end
         default: begin
            for (int i = 0; i < ID_SPACE; i++) begin
               if (held[i] && held_expiry[i] <= now) begin
                  held[i] = 1'b0;
               end
            end
         end
      endcase
   endtask

   function automatic logic [ID_BITS-1:0] pick_id(input bit want_held);
      int ids[$];
      for (int i = 0; i < ID_SPACE; i++) begin
         if (held[i] == want_held) begin
            ids.push_back(i);
         end
      end
      if (ids.size() == 0) begin
         return ID_BITS'($urandom_range(0, ID_SPACE - 1));
      end
      return ID_BITS'(ids[$urandom_range(0, ids.size() - 1)]);
   endfunction

   task automatic send_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      // advance the clock of the timers now and then so older ones come due
      if ($urandom_range(0, 24) == 0) begin
         base_time = base_time + TIME_BITS'($urandom_range(20, 60));
      end
      if (pick < 38) begin
         send_request(OP_ADD, pick_id(1'b0), base_time + TIME_BITS'($urandom_range(0, 40)),
                      $urandom);
      end else if (pick < 50) begin
         send_request(OP_ADJUST, pick_id(1'b1), base_time + TIME_BITS'($urandom_range(0, 40)),
                      $urandom);
      end else if (pick < 60) begin
         send_request(OP_DELETE, pick_id(1'b1), $urandom, $urandom);
      end else if (pick < 80) begin
         send_request(OP_TICK, ID_BITS'($urandom_range(0, ID_SPACE - 1)), $urandom,
                      base_time + TIME_BITS'($urandom_range(0, 30)));
      end else if (pick < 82) begin
         send_request(OP_TICK, ID_BITS'($urandom_range(0, ID_SPACE - 1)), $urandom, '1);
      end else if (pick < 91) begin
         send_request(2'($urandom_range(0, 3)), ID_BITS'($urandom_range(0, ID_SPACE - 1)),
                      $urandom, $urandom);
      end else begin
         case ($urandom_range(0, 2))
            0:       send_request(OP_ADD, pick_id(1'b1), $urandom, $urandom);
            1:       send_request(OP_ADJUST, pick_id(1'b0), $urandom, $urandom);
            default: send_request(OP_DELETE, pick_id(1'b0), $urandom, $urandom);
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // sender mostly busy, receiver mostly stalled
      send_request(OP_TICK, 6'd0, '0, '0);
      send_request(OP_ADD, 6'd0, '1, $urandom);
      send_request(OP_ADD, 6'd63, '0, $urandom);
      send_request(OP_TICK, 6'd63, '1, '0);
      send_request(OP_ADD, 6'd63, '0, $urandom);
      send_request(OP_ADD, 6'd5, 32'd100, $urandom);
      send_request(OP_ADD, 6'd6, 32'd100, $urandom);
      send_request(OP_ADD, 6'd7, 32'd100, $urandom);
      send_request(OP_ADD, 6'd5, 32'd1, $urandom);
      send_request(OP_ADJUST, 6'd9, 32'd10, $urandom);
      send_request(OP_DELETE, 6'd10, $urandom, $urandom);
      send_request(OP_ADJUST, 6'd6, 32'd50, $urandom);
      send_request(OP_ADJUST, 6'd5, 32'd100, $urandom);
      send_request(OP_ADJUST, 6'd63, 32'd200, $urandom);
      send_request(OP_DELETE, 6'd7, $urandom, $urandom);
      send_request(OP_TICK, 6'd63, '1, 32'd49);
      send_request(OP_TICK, 6'd0, '0, 32'd100);
      send_request(OP_TICK, 6'd21, $urandom, 32'hFFFF_FFFE);
      send_request(OP_TICK, 6'd42, $urandom, '1);
      send_request(OP_DELETE, 6'd0, $urandom, $urandom);
      base_time = $urandom;
      repeat (100) send_random_request();

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 72;
      recv_idle_pct = 7;
      base_time     = $urandom;
      repeat (120) send_random_request();

      // full speed: fill the queue, drain it with one tick, then mix
      send_idle_pct = 0;
      recv_idle_pct = 0;
      base_time     = $urandom;
      for (int i = 0; i < ID_SPACE; i++) begin
         if (!held[i]) begin
            send_request(OP_ADD, ID_BITS'(i), base_time + TIME_BITS'($urandom_range(0, 63)),
                         $urandom);
         end
      end
      send_request(OP_ADD, ID_BITS'($urandom_range(0, ID_SPACE - 1)), $urandom, $urandom);
      send_request(OP_TICK, ID_BITS'($urandom_range(0, ID_SPACE - 1)), $urandom, '1);
      repeat (60) send_random_request();

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d adds, %0d adjusts, %0d deletes and %0d ticks under three stall patterns",
               sent_by_op[OP_ADD], sent_by_op[OP_ADJUST], sent_by_op[OP_DELETE],
               sent_by_op[OP_TICK]);
      $display("Checked %0d results, %0d of them expired timers, including a full-queue drain",
               results_checked, timers_expired);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
